FILE: rtl/core/tcpq_pkg.sv
// Shared types and codes for the two-class priority queue core.
// Used by the controller, the datapath and the top level; depends on nothing.
package tcpq_pkg;

  // Operation codes carried in the mode field.
  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_CLR = 2'd2;

  localparam int unsigned OUT_DW   = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned S_USER_W = 3;
  localparam int unsigned M_DATA_W = 112;

  // Controller to datapath.
  typedef struct packed {
    logic load_op;     // capture the incoming beat
    logic exec;        // apply the operation to the queues
    logic cap_served;  // capture the word read from the old head
    logic load_out;    // load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_stall;   // result register holds a beat that is not taken
  } status_t;

endpackage

FILE: rtl/core/tcpq_fifo.sv
// One bounded circular queue: storage array, head pointer and fill count.
// Both head and tail words are read every cycle with registered read data.
// Depends on nothing.
module tcpq_fifo #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         push,
  input  logic                         pop,
  input  logic [DW-1:0]                wdata,
  output logic [$clog2(DEPTH+1)-1:0]   fill,
  output logic                         full,
  output logic [DW-1:0]                head_data,
  output logic [DW-1:0]                tail_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] fill_next;
  logic [SW-1:0] wr_sum;
  logic [SW-1:0] last_sum;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] last_addr;

  assign full = (fill == CW'(DEPTH));

  // Position sums stay below twice the depth, so one compare and subtract wraps them.
  always_comb begin
    wr_sum   = SW'(head) + SW'(fill);
    last_sum = wr_sum - SW'(1);
    wr_addr  = (wr_sum >= SW'(DEPTH)) ? AW'(wr_sum - SW'(DEPTH)) : AW'(wr_sum);
    if (fill == '0) begin
      last_addr = head;
    end else if (last_sum >= SW'(DEPTH)) begin
      last_addr = AW'(last_sum - SW'(DEPTH));
    end else begin
      last_addr = AW'(last_sum);
    end
  end

  always_comb begin
    head_next = head;
    fill_next = fill;
    if (clr) begin
      head_next = '0;
      fill_next = '0;
    end else if (push) begin
      fill_next = fill + CW'(1);
    end else if (pop) begin
      head_next = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      fill_next = fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !clr) begin
      mem[wr_addr] <= wdata;
    end
    head_data <= mem[head];
    tail_data <= mem[last_addr];
  end

endmodule

FILE: rtl/core/tcpq_dp.sv
// Datapath: operation register, the two queues, served word and result register.
// Depends on tcpq_pkg and tcpq_fifo.
module tcpq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tcpq_pkg::cmd_t                cmd,
  output tcpq_pkg::status_t             status,
  input  logic [tcpq_pkg::S_DATA_W-1:0] in_data,
  input  logic [tcpq_pkg::S_USER_W-1:0] in_user,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcpq_pkg::M_DATA_W-1:0] out_data
);

  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ODW = tcpq_pkg::OUT_DW;

  logic [1:0]            op_mode;
  logic                  op_prio;
  logic [DATA_WIDTH-1:0] op_data;

  logic                  h_push, h_pop, n_push, n_pop, q_clr;
  logic [CW-1:0]         h_fill, n_fill;
  logic                  h_full, n_full;
  logic [DATA_WIDTH-1:0] h_head, h_tail, n_head, n_tail;

  logic                  ok;
  logic                  ok_next;
  logic                  popped_h;
  logic                  popped_n;
  logic [ODW-1:0]        served;
  logic [ODW-1:0]        front;
  logic [ODW-1:0]        back;

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_mode <= in_user[1:0];
      op_prio <= in_user[2];
      op_data <= DATA_WIDTH'(in_data);
    end
  end

  always_comb begin
    h_push  = 1'b0;
    n_push  = 1'b0;
    h_pop   = 1'b0;
    n_pop   = 1'b0;
    q_clr   = 1'b0;
    ok_next = 1'b0;
    if (cmd.exec) begin
      case (op_mode)
        tcpq_pkg::OP_ENQ: begin
          if (op_prio) begin
            h_push  = !h_full;
            ok_next = !h_full;
          end else begin
            n_push  = !n_full;
            ok_next = !n_full;
          end
        end
        tcpq_pkg::OP_DEQ: begin
          h_pop   = (h_fill != '0);
          n_pop   = (h_fill == '0) && (n_fill != '0);
          ok_next = (h_fill != '0) || (n_fill != '0);
        end
        tcpq_pkg::OP_CLR: begin
          q_clr   = 1'b1;
          ok_next = 1'b1;
        end
        default: ok_next = 1'b0;
      endcase
    end
  end

  tcpq_fifo #(.DEPTH(QUEUE_DEPTH), .DW(DATA_WIDTH)) u_high (
    .clk       (clk),
    .rst       (rst),
    .clr       (q_clr),
    .push      (h_push),
    .pop       (h_pop),
    .wdata     (op_data),
    .fill      (h_fill),
    .full      (h_full),
    .head_data (h_head),
    .tail_data (h_tail)
  );

  tcpq_fifo #(.DEPTH(QUEUE_DEPTH), .DW(DATA_WIDTH)) u_normal (
    .clk       (clk),
    .rst       (rst),
    .clr       (q_clr),
    .push      (n_push),
    .pop       (n_pop),
    .wdata     (op_data),
    .fill      (n_fill),
    .full      (n_full),
    .head_data (n_head),
    .tail_data (n_tail)
  );

  // The head word read in the execute cycle is the entry being removed.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok       <= ok_next;
      popped_h <= h_pop;
      popped_n <= n_pop;
    end
    if (cmd.cap_served) begin
      if (popped_h) begin
        served <= ODW'(h_head);
      end else if (popped_n) begin
        served <= ODW'(n_head);
      end else begin
        served <= '0;
      end
    end
  end

  always_comb begin
    front = '0;
    back  = '0;
    if (h_fill != '0) begin
      front = ODW'(h_head);
    end else if (n_fill != '0) begin
      front = ODW'(n_head);
    end
    if (n_fill != '0) begin
      back = ODW'(n_tail);
    end else if (h_fill != '0) begin
      back = ODW'(h_tail);
    end
  end

  assign status.out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {4'b0,
                   (h_fill == '0) && (n_fill == '0),
                   tcpq_pkg::COUNT_W'(n_fill),
                   tcpq_pkg::COUNT_W'(h_fill),
                   back,
                   front,
                   served,
                   ok};
    end
  end

endmodule

FILE: rtl/core/tcpq_ctrl.sv
// Controller state machine: sequences accept, execute, read-back and result load.
// Depends on tcpq_pkg.
module tcpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcpq_pkg::status_t status,
  output tcpq_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.cap_served = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/two_class_priority_queue_core.sv
// Two-class strict priority queue, top level.
// An accepted beat passes the execute, read-back and result-load states before m_tvalid; the
// load waits while the last result is not taken, and no new beat is accepted meanwhile, as the
// registered read of the queue storage (old head, then new head and tail) needs those states.
// Reset clears the controller, both head pointers and fill counts and the result
// valid; queue storage is not cleared and its words reach the result only where an entry is held.
module two_class_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // entry_data
  input  logic [2:0]   s_tuser,   // mode[1:0], high_priority[2]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata    // accepted, served_data, front_data, back_data,
                                  // high_count, normal_count, is_empty, zero fill
);

  tcpq_pkg::cmd_t    cmd;
  tcpq_pkg::status_t status;

  tcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tcpq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
